FILE: design/fpba_pkg.sv
`timescale 1ns / 1ps

package fpba_pkg;

    localparam int BLOCKS    = 16;
    localparam int SIZE_BITS = 16;
    localparam int IDX_W     = $clog2(BLOCKS);
    localparam int CNT_W     = $clog2(BLOCKS + 1);
    localparam int CFG_W     = 5;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_REQ  = 1'b1;

    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_NUM    = 1'b1;

    // search token handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [IDX_W-1:0]     pick;
        logic [SIZE_BITS-1:0] value;
    } t_token;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic [1:0]           policy;
        logic [CNT_W-1:0]     limit;
        logic [SIZE_BITS-1:0] size;
        logic                 load_en;
        logic [IDX_W-1:0]     load_idx;
        logic [SIZE_BITS-1:0] load_data;
        logic                 sub_en;
        logic [IDX_W-1:0]     sub_idx;
    } t_cmd;

endpackage

FILE: design/fpba_cell.sv
`timescale 1ns / 1ps

module fpba_cell (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [fpba_pkg::IDX_W-1:0]            i_index,
    input  fpba_pkg::t_cmd                        i_cmd,
    input  fpba_pkg::t_token                      i_tok,
    output fpba_pkg::t_token                      o_tok
);

    logic [fpba_pkg::SIZE_BITS-1:0] r_cap;
    fpba_pkg::t_token               r_tok;
    fpba_pkg::t_token               n_tok;
    logic                           w_fits;
    logic                           w_take;

    assign w_fits = (fpba_pkg::CNT_W'(i_index) < i_cmd.limit)
                    && (r_cap >= i_cmd.size);

    always_comb begin
        w_take = 1'b0;
        if (w_fits) begin
            if (!i_tok.found) begin
                w_take = 1'b1;
            end else if (i_cmd.policy == fpba_pkg::POL_BEST) begin
                w_take = (r_cap < i_tok.value);
            end else if (i_cmd.policy == fpba_pkg::POL_WORST) begin
                w_take = (r_cap > i_tok.value);
            end
        end
        n_tok = i_tok;
        if (w_take) begin
            n_tok.found = 1'b1;
            n_tok.pick  = i_index;
            n_tok.value = r_cap;
        end
    end

    // capacity: load from the broadcast, or debit the granted size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= '0;
        end else if (i_cmd.load_en && (i_cmd.load_idx == i_index)) begin
            r_cap <= i_cmd.load_data;
        end else if (i_cmd.sub_en && (i_cmd.sub_idx == i_index)) begin
            r_cap <= r_cap - i_cmd.size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.found <= n_tok.found;
        r_tok.pick  <= n_tok.pick;
        r_tok.value <= n_tok.value;
    end

    assign o_tok = r_tok;

endmodule

FILE: design/fit_policy_block_allocator_top.sv
`timescale 1ns / 1ps
// Load item: accepted whenever busy is low; it writes the cell at the accept edge.
// Request item: the search token walks one cell per cycle down a row of BLOCKS cells,
//   then into the result registers; busy falls as the strobe rises, ready for the next item.
// The result is shown for exactly one cycle; the receiver cannot stall.
// Reset (synchronous, active low): all capacities zero, fit_policy first fit, num_blocks 16.
module fit_policy_block_allocator_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [fpba_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_func,
    input  logic [fpba_pkg::IDX_W-1:0]           i_block_index,
    input  logic [fpba_pkg::SIZE_BITS-1:0]       i_block_capacity,
    input  logic [fpba_pkg::SIZE_BITS-1:0]       i_request_size,
    output logic                                 o_result_valid,
    output logic                                 o_granted,
    output logic [fpba_pkg::IDX_W-1:0]           o_block_number,
    output logic [fpba_pkg::SIZE_BITS-1:0]       o_remaining_after
);

    // configuration
    logic [1:0]                     r_policy;
    logic [fpba_pkg::CFG_W-1:0]     r_num_blocks;

    // per-request state, held for the whole scan
    logic                           r_busy;
    logic                           r_inject;
    logic [1:0]                     r_req_policy;
    logic [fpba_pkg::CNT_W-1:0]     r_limit;
    logic [fpba_pkg::SIZE_BITS-1:0] r_size;

    logic                           r_result_valid;
    logic                           r_granted;
    logic [fpba_pkg::IDX_W-1:0]     r_block_number;
    logic [fpba_pkg::SIZE_BITS-1:0] r_remaining;

    logic                           w_accept;
    logic                           w_done;
    logic [fpba_pkg::CNT_W-1:0]     w_limit;
    fpba_pkg::t_cmd                 w_cmd;
    fpba_pkg::t_token               w_tok [0:fpba_pkg::BLOCKS];

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    // saturate the search length to the number of cells
    assign w_limit = (r_num_blocks > fpba_pkg::CFG_W'(fpba_pkg::BLOCKS))
                     ? fpba_pkg::CNT_W'(fpba_pkg::BLOCKS)
                     : fpba_pkg::CNT_W'(r_num_blocks);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy     <= fpba_pkg::POL_FIRST;
            r_num_blocks <= fpba_pkg::CFG_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fpba_pkg::CFG_POLICY: r_policy     <= i_cfg_data[1:0];
                fpba_pkg::CFG_NUM:    r_num_blocks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // token leaving the last cell closes the scan
    assign w_done = w_tok[fpba_pkg::BLOCKS].valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_inject       <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_inject       <= w_accept && (i_func == fpba_pkg::FUNC_REQ);
            r_result_valid <= w_done;
            if (w_accept && (i_func == fpba_pkg::FUNC_REQ)) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // capture request parameters; hold them until the scan ends
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_func == fpba_pkg::FUNC_REQ)) begin
            r_req_policy <= r_policy;
            r_limit      <= w_limit;
            r_size       <= i_request_size;
        end
    end

    // result registers; a refusal reports zero number and zero leftover
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_granted <= w_tok[fpba_pkg::BLOCKS].found;
            if (w_tok[fpba_pkg::BLOCKS].found) begin
                r_block_number <= w_tok[fpba_pkg::BLOCKS].pick;
                r_remaining    <= w_tok[fpba_pkg::BLOCKS].value - r_size;
            end else begin
                r_block_number <= '0;
                r_remaining    <= '0;
            end
        end
    end

    // broadcast: loads write at the accept edge, a grant debits at the done edge
    always_comb begin
        w_cmd.policy    = r_req_policy;
        w_cmd.limit     = r_limit;
        w_cmd.size      = r_size;
        w_cmd.load_en   = w_accept && (i_func == fpba_pkg::FUNC_LOAD);
        w_cmd.load_idx  = i_block_index;
        w_cmd.load_data = i_block_capacity;
        w_cmd.sub_en    = w_done && w_tok[fpba_pkg::BLOCKS].found;
        w_cmd.sub_idx   = w_tok[fpba_pkg::BLOCKS].pick;
    end

    // fresh token enters the first cell in the cycle after the accept
    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].valid = r_inject;
    end

    for (genvar g = 0; g < fpba_pkg::BLOCKS; g++) begin : g_cell
        fpba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (fpba_pkg::IDX_W'(g)),
            .i_cmd   (w_cmd),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign o_result_valid    = r_result_valid;
    assign o_granted         = r_granted;
    assign o_block_number    = r_block_number;
    assign o_remaining_after = r_remaining;

    // a refusal carries zero number and zero leftover
    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_granted) |-> (o_block_number == '0 && o_remaining_after == '0))
        else $error("refusal with nonzero payload");

    // busy drops exactly when the result is shown
    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("busy dropped without a result");

    // one request at a time: strobes never sit back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    // a result only follows a scan that held busy
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without a pending request");

endmodule
